// ----- rtl/s256_pkg.sv -----
`default_nettype none
package s256_pkg;

    localparam int DIGEST_WORDS = 8;
    localparam int ROUNDS       = 64;
    localparam int BLK_WORDS    = 16;
    localparam int HASH_WORDS   = 8;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [31:0] t_word;

    localparam t_word K_TAB [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word H_INIT [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_sig0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sig1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word sml_sig0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word sml_sig1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word f_ch(input t_word e, input t_word f, input t_word g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic t_word f_maj(input t_word a, input t_word b, input t_word c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/s256_if.sv -----
`default_nettype none
interface s256_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface s256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        last_word;

    modport source (output valid, output digest_word, output last_word, input ready);
    modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface
`default_nettype wire

// ----- rtl/sha256_hash_engine.sv -----
`default_nettype none
// Channel  Dir  Payload                      Note
// i_msg    in   mode, data_byte              one byte or a finish per word
// o_dig    out  digest_word, last_word       DIGEST_WORDS words per finish
//
// An absorb word is packed into the block buffer; the 64th byte of a block
// starts a compression of hash load, 64 rounds in the single round unit
// and hash update, and no new byte is taken until it ends. A finish adds
// padding writes, one or two compressions and, for each digest word, a
// hash memory read and an output register load. Reset marks the hash
// memory as holding the initial values; the block buffer needs no clear.
// Input is taken only in IDLE; the output register holds while o_dig stalls.
module sha256_hash_engine (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    s256_in_if.sink     i_msg,
    s256_out_if.source  o_dig
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]  r_state;
    logic [5:0]  r_cnt;
    logic        r_ph;
    logic        r_fresh;   // hash memory still logically holds the initial values
    logic        r_fin;     // finishing a message
    logic        r_extra;   // current pad block is the first of two
    logic [63:0] r_bits;
    logic [23:0] r_acc;
    s256_pkg::t_word r_v [8];
    s256_pkg::t_word r_w [16];
    logic        r_ovalid;
    s256_pkg::t_word r_odata;
    logic        r_olast;

    logic        buf_we;
    logic [3:0]  buf_waddr;
    s256_pkg::t_word buf_wdata;
    logic [3:0]  buf_raddr;
    s256_pkg::t_word buf_rd;

    logic        h_we;
    s256_pkg::t_word h_wdata;
    s256_pkg::t_word h_rd;
    s256_pkg::t_word hval;
    logic [2:0]  hidx;

    logic [5:0]  used;
    s256_pkg::t_word w_t, t1, t2, pad_word;
    logic        in_acc, out_free;

    assign used     = r_bits[8:3];
    assign in_acc   = i_msg.valid && i_msg.ready;
    assign out_free = !r_ovalid || o_dig.ready;

    assign i_msg.ready       = (r_state == ST_IDLE);
    assign o_dig.valid       = r_ovalid;
    assign o_dig.digest_word = r_odata;
    assign o_dig.last_word   = r_olast;

    s256_ram #(.WIDTH(32), .DEPTH(s256_pkg::BLK_WORDS)) u_blk (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rd)
    );

    s256_ram #(.WIDTH(32), .DEPTH(s256_pkg::HASH_WORDS)) u_hash (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (hidx),
        .i_wdata (h_wdata),
        .i_raddr (r_cnt[2:0]),
        .o_rdata (h_rd)
    );

    // read data is registered and arrives in the cycle after the address, so it belongs to cnt-1
    assign hidx    = r_cnt[2:0] - 3'd1;
    assign hval    = r_fresh ? s256_pkg::H_INIT[hidx] : h_rd;
    assign h_we    = (r_state == ST_UPD) && (r_cnt != 6'd0);
    assign h_wdata = hval + r_v[0];

    // last partial word of the message closed by the pad byte
    always_comb begin
        unique case (used[1:0])
            2'd0:    pad_word = {s256_pkg::PAD_BYTE, 24'h0};
            2'd1:    pad_word = {r_acc[7:0], s256_pkg::PAD_BYTE, 16'h0};
            2'd2:    pad_word = {r_acc[15:0], s256_pkg::PAD_BYTE, 8'h0};
            default: pad_word = {r_acc, s256_pkg::PAD_BYTE};
        endcase
    end

    always_comb begin
        buf_we    = 1'b0;
        buf_waddr = used[5:2];
        buf_wdata = {r_acc, i_msg.data_byte};
        if (r_state == ST_IDLE && in_acc) begin
            if (i_msg.mode) begin
                buf_we    = 1'b1;
                buf_wdata = pad_word;
            end else begin
                buf_we = (used[1:0] == 2'd3);
            end
        end else if (r_state == ST_PAD) begin
            buf_we    = 1'b1;
            buf_waddr = r_cnt[3:0];
            if (!r_extra && r_cnt[3:0] == 4'd14) begin
                buf_wdata = r_bits[63:32];
            end else if (!r_extra && r_cnt[3:0] == 4'd15) begin
                buf_wdata = r_bits[31:0];
            end else begin
                buf_wdata = '0;
            end
        end
    end

    // block word t is fetched in the cycle before round t
    assign buf_raddr = (r_state == ST_RND) ? (r_cnt[3:0] + 4'd1) : 4'd0;

    assign w_t = (r_cnt < 6'd16) ? buf_rd
               : r_w[0] + s256_pkg::sml_sig0(r_w[1]) + r_w[9] + s256_pkg::sml_sig1(r_w[14]);
    assign t1  = r_v[7] + s256_pkg::big_sig1(r_v[4]) + s256_pkg::f_ch(r_v[4], r_v[5], r_v[6])
               + s256_pkg::K_TAB[r_cnt] + w_t;
    assign t2  = s256_pkg::big_sig0(r_v[0]) + s256_pkg::f_maj(r_v[0], r_v[1], r_v[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ph     <= 1'b0;
            r_fresh  <= 1'b1;
            r_fin    <= 1'b0;
            r_extra  <= 1'b0;
            r_bits   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && o_dig.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_msg.mode) begin
                            r_fin   <= 1'b1;
                            r_extra <= (used[5:2] >= 4'd14);
                            if (used[5:2] == 4'd15) begin
                                r_cnt   <= '0;
                                r_state <= ST_LOAD;
                            end else begin
                                r_cnt   <= {2'b00, used[5:2] + 4'd1};
                                r_state <= ST_PAD;
                            end
                        end else begin
                            r_bits <= r_bits + 64'd8;
                            r_acc  <= {r_acc[15:0], i_msg.data_byte};
                            if (used == 6'd63) begin
                                r_cnt   <= '0;
                                r_state <= ST_LOAD;
                            end
                        end
                    end
                end
                ST_PAD: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt[3:0] == 4'd15) begin
                        r_cnt   <= '0;
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd8) begin
                        r_cnt   <= '0;
                        r_state <= ST_RND;
                    end
                end
                ST_RND: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(s256_pkg::ROUNDS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd8) begin
                        r_fresh <= 1'b0;
                        r_cnt   <= '0;
                        if (!r_fin) begin
                            r_state <= ST_IDLE;
                        end else if (r_extra) begin
                            r_extra <= 1'b0;
                            r_state <= ST_PAD;
                        end else begin
                            r_ph    <= 1'b0;
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ph     <= 1'b0;
                        r_cnt    <= r_cnt + 6'd1;
                        if (r_cnt == 6'(s256_pkg::DIGEST_WORDS - 1)) begin
                            r_fresh <= 1'b1;
                            r_fin   <= 1'b0;
                            r_bits  <= '0;
                            r_cnt   <= '0;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD && r_cnt != 6'd0) begin
            for (int i = 0; i < 7; i++) begin
                r_v[i] <= r_v[i+1];
            end
            r_v[7] <= hval;
        end else if (r_state == ST_UPD && r_cnt != 6'd0) begin
            for (int i = 0; i < 7; i++) begin
                r_v[i] <= r_v[i+1];
            end
            r_v[7] <= '0;
        end else if (r_state == ST_RND) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (r_state == ST_RND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_t;
        end
        if (r_state == ST_EMIT && r_ph && out_free) begin
            r_odata <= h_rd;
            r_olast <= (r_cnt == 6'(s256_pkg::DIGEST_WORDS - 1));
        end
    end
endmodule
`default_nettype wire

// ----- rtl/s256_ram.sv -----
`default_nettype none
module s256_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`default_nettype none
module testbench;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_DIGEST = (s256_pkg::DIGEST_WORDS < 8) ? s256_pkg::DIGEST_WORDS : 8;

    typedef enum logic {
        MODE_ABSORB = 1'b0,
        MODE_FINISH = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] data_byte;
    } t_msg_word;

    typedef struct packed {
        s256_pkg::t_word digest_word;
        logic            last_word;
    } t_dig_word;

    logic i_clk;
    logic i_rst_n;

    s256_in_if  msg_if ();
    s256_out_if dig_if ();

    sha256_hash_engine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_if.sink),
        .o_dig   (dig_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    // Shadow hash state, updated as each word is accepted.
    s256_pkg::t_word hash_state [8];
    logic [7:0] blk_bytes  [64];
    logic [63:0] msg_bits;

    t_msg_word  pending_words [$];
    t_dig_word  digest_queue  [$];
    int         mismatches;
    int         digests_seen;
    int         messages_sent;
    int         bytes_sent;
    bit         quiet_idle;    // long stretch with no idling
    bit         hold_sender;   // pause until every digest word has drained
    bit         stim_done;
    int         stall_cycles;

    function automatic s256_pkg::t_word ror32(s256_pkg::t_word x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One SHA-256 compression of blk_bytes into hash_state.
    function automatic void compress();
        s256_pkg::t_word sched [64];
        s256_pkg::t_word v [8];
        s256_pkg::t_word t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            sched[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
            s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + s256_pkg::K_TAB[i] + sched[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++) hash_state[i] = s256_pkg::H_INIT[i];
        msg_bits = '0;
    endfunction

    // Advance the shadow state by one word; a finish queues the digest.
    function automatic void digest_predict(t_msg_word w);
        int used;
        used = int'(msg_bits[8:3]);
        if (w.mode == MODE_ABSORB) begin
            blk_bytes[used] = w.data_byte;
            msg_bits += 64'd8;
            if (used == 63) compress();
            return;
        end
        blk_bytes[used] = s256_pkg::PAD_BYTE;
        used++;
        if (used > 56) begin
            for (int i = used; i < 64; i++) blk_bytes[i] = 8'h00;
            compress();
            used = 0;
        end
        for (int i = used; i < 56; i++) blk_bytes[i] = 8'h00;
        for (int i = 0; i < 8; i++) blk_bytes[56+i] = msg_bits[63-8*i -: 8];
        compress();
        for (int j = 0; j < N_DIGEST; j++)
            digest_queue.push_back('{hash_state[j], (j == N_DIGEST - 1)});
        restart_message();
    endfunction

    function automatic void add_message(int len, int pattern);
        t_msg_word w;
        for (int i = 0; i < len; i++) begin
            w.mode = MODE_ABSORB;
            case (pattern)
                0: w.data_byte = 8'h00;
                1: w.data_byte = 8'hff;
                default: w.data_byte = 8'($urandom_range(0, 255));
            endcase
            pending_words.push_back(w);
        end
        w.mode = MODE_FINISH;
        w.data_byte = 8'($urandom_range(0, 255));   // ignored on finish
        pending_words.push_back(w);
    endfunction

    function automatic bit idle_roll();
        return !quiet_idle && ($urandom_range(0, 99) < 9);
    endfunction

    // Driver: presents queued words, holds a word until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            msg_if.valid <= 1'b0;
        end else begin
            if (msg_if.valid && msg_if.ready) begin
                digest_predict('{t_mode'(msg_if.mode), msg_if.data_byte});
                if (msg_if.mode == MODE_FINISH) messages_sent++;
                else bytes_sent++;
            end
            if (!(msg_if.valid && !msg_if.ready)) begin
                if (pending_words.size() > 0 && !idle_roll()
                    && !(hold_sender && (digest_queue.size() > 0
                         || (msg_if.valid && msg_if.ready
                             && msg_if.mode == MODE_FINISH)))) begin
                    msg_if.valid     <= 1'b1;
                    msg_if.mode      <= pending_words[0].mode;
                    msg_if.data_byte <= pending_words[0].data_byte;
                    void'(pending_words.pop_front());
                end else begin
                    msg_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each digest word against the oldest expectation.
    always @(posedge i_clk) begin
        t_dig_word want;
        if (!i_rst_n) begin
            dig_if.ready <= 1'b0;
        end else begin
            if (dig_if.valid && dig_if.ready) begin
                digests_seen++;
                if (digest_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected digest word %h last %b",
                                 dig_if.digest_word, dig_if.last_word);
                end else begin
                    want = digest_queue.pop_front();
                    if (dig_if.digest_word !== want.digest_word
                        || dig_if.last_word !== want.last_word) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest mismatch: want %h/%b got %h/%b",
                                     want.digest_word, want.last_word,
                                     dig_if.digest_word, dig_if.last_word);
                    end
                end
            end
            dig_if.ready <= !idle_roll();
        end
    end

    // Watchdog on cycles with no accepted word on either side, idle once stimulus and digests are done.
    always @(posedge i_clk) begin
        if (!i_rst_n || (msg_if.valid && msg_if.ready) || (dig_if.valid && dig_if.ready)
            || (stim_done && digest_queue.size() == 0))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress in %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int len;
        i_clk = 0;
        i_rst_n = 0;
        msg_if.valid = 0;
        msg_if.mode = 0;
        msg_if.data_byte = 0;
        dig_if.ready = 0;
        mismatches = 0;
        digests_seen = 0;
        messages_sent = 0;
        bytes_sent = 0;
        quiet_idle = 0;
        hold_sender = 0;
        stim_done = 0;
        stall_cycles = 0;
        restart_message();

        // Directed: empty message, all-zero and all-ones bytes.
        add_message(0, 2);
        add_message(3, 0);
        add_message(2, 1);
        add_message(0, 2);       // back-to-back finishes
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Length 55 fits in one block; 56 and 61 spill into an extra pad block.
        add_message(55, 2);
        add_message(56, 2);
        add_message(61, 2);

        // Exactly one full block before padding, with no idling on either side while it is sent.
        wait (pending_words.size() == 0);
        quiet_idle = 1;
        add_message(64, 1);
        wait (pending_words.size() == 0);
        quiet_idle = 0;

        // Hold off until everything drains.
        wait (pending_words.size() == 0);
        hold_sender = 1;
        add_message(1, 2);
        wait (pending_words.size() == 0 && digest_queue.size() == 0);
        hold_sender = 0;

        for (int m = 0; m < 2; m++) begin
            len = $urandom_range(0, 7);
            add_message(len, 2);
        end
        wait (pending_words.size() == 0 && !msg_if.valid);
        stim_done = 1;
        wait (digest_queue.size() == 0);
        repeat (200) @(posedge i_clk);

        $display("covered %0d messages, %0d bytes, %0d digest words",
                 messages_sent, bytes_sent, digests_seen);
        $display("cases: empty, pad spill at 56 and 61, full block, stalls on both sides");
        if (mismatches == 0 && digest_queue.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
